FILE: sv/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a clocked property, skip while reset is high
`define LSPT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lspt assertion failed");

// Check that a condition implies a consequence in the same cycle
`define LSPT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lspt assertion failed");

`endif

FILE: sv/lspt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lspt_pkg;

   typedef enum logic [2:0] {
      ACT_LOOKUP  = 3'd0,
      ACT_FIND    = 3'd1,
      ACT_MARK    = 3'd2,
      ACT_ADVANCE = 3'd3,
      ACT_SWEEP   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   localparam logic CSR_UNLOAD_DIST = 1'b0;
   localparam logic [15:0] UNLOAD_DIST_RESET = 16'd8;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [5:0]         slot_index;
      logic               allocated_new;
      logic               evicted;
      logic signed [31:0] evicted_key;
      logic               dirty_state;
      logic [6:0]         live_count;
      logic [6:0]         unloaded_count;
   } rsp_type;

   typedef struct packed {
      logic key_eq;
      logic stamp_lt;
      logic far;
   } cmp_type;

endpackage

`default_nettype wire

FILE: sv/lspt_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lspt_slot_mem #(
   parameter int SLOTS = 64,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  wire logic               clock,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output logic signed [31:0]      rd_key,
   output logic [31:0]             rd_stamp,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire logic signed [31:0] wr_key,
   input  wire logic [31:0]        wr_stamp
);

   logic [31:0] key_mem [SLOTS];
   logic [31:0] stamp_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_key   <= key_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/lspt_cmp_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module lspt_cmp_unit (
   input  wire logic signed [31:0] slot_key,
   input  wire logic [31:0]        slot_stamp,
   input  wire logic signed [31:0] ref_key,
   input  wire logic [31:0]        ref_stamp,
   input  wire logic [15:0]        distance,
   output lspt_pkg::cmp_type       cmp
);

   logic signed [32:0] diff;
   logic [32:0]        mag;

   always_comb begin
      diff = 33'(slot_key) - 33'(ref_key);
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      cmp.key_eq   = (slot_key == ref_key);
      cmp.stamp_lt = (slot_stamp < ref_stamp);
      cmp.far      = (mag > {17'd0, distance});
   end

endmodule

`default_nettype wire

FILE: sv/lru_slot_pool_table_unit.sv
// Channel   Ports                        Handshake
// request   start, busy, req_data        taken when start is high and busy is low
// result    rsp_strobe, rsp_data         shown for one cycle, always taken
// config    psel, penable, pwrite, ...   written on psel & penable & pwrite
//
// Lookup, find, mark-dirty and unload-sweep scan every slot from accept to
// result: the key/stamp memory has one registered read port and each slot
// passes a read state and then a compare state. Advance-frame and unused
// actions give their result in the cycle after accept. Reset is synchronous
// and clears the active and dirty bits, the live and frame counters and the
// state; busy stays high while a scan runs. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module lru_slot_pool_table_unit #(
   parameter int SLOTS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lspt_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output lspt_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   lspt_pkg::state_type state_ff, state_in;
   logic [2:0]          act_ff, act_in;
   logic signed [31:0]  key_ff, key_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    old_idx_ff, old_idx_in;
   logic [31:0]         old_stamp_ff, old_stamp_in;
   logic signed [31:0]  old_key_ff, old_key_in;
   logic [CNT_W-1:0]    unl_ff, unl_in;
   logic [SLOTS-1:0]    active_ff, active_in;
   logic [SLOTS-1:0]    dirty_ff, dirty_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [31:0]         frame_ff, frame_in;
   logic [15:0]         dist_ff, dist_in;
   lspt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic signed [31:0]  rd_key;
   logic [31:0]         rd_stamp;
   logic [IDX_W-1:0]    sel_idx;
   lspt_pkg::cmp_type   cmp;

   lspt_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock    (clock),
      .rd_addr  (idx_ff),
      .rd_key   (rd_key),
      .rd_stamp (rd_stamp),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff),
      .wr_stamp (frame_ff)
   );

   lspt_cmp_unit u_cmp (
      .slot_key   (rd_key),
      .slot_stamp (rd_stamp),
      .ref_key    (key_ff),
      .ref_stamp  (old_stamp_ff),
      .distance   (dist_ff),
      .cmp        (cmp)
   );

   assign busy       = (state_ff != lspt_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == lspt_pkg::CSR_UNLOAD_DIST) ? {16'd0, dist_ff} : 32'd0;

   always_comb begin
      dist_in = dist_ff;
      if (psel && penable && pwrite && (paddr[2] == lspt_pkg::CSR_UNLOAD_DIST)) begin
         dist_in = pwdata[15:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_idx_in   = old_idx_ff;
      old_stamp_in = old_stamp_ff;
      old_key_in   = old_key_ff;
      unl_in       = unl_ff;
      active_in    = active_ff;
      dirty_in     = dirty_ff;
      count_in     = count_ff;
      frame_in     = frame_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      sel_idx      = free_ff ? free_idx_ff : old_idx_ff;

      case (state_ff)
         lspt_pkg::ST_IDLE: begin
            if (start) begin
               act_in = req_data.action;
               key_in = req_data.key;
               if (req_data.action inside {lspt_pkg::ACT_LOOKUP, lspt_pkg::ACT_FIND,
                                           lspt_pkg::ACT_MARK, lspt_pkg::ACT_SWEEP}) begin
                  state_in = lspt_pkg::ST_READ;
                  idx_in   = '0;
                  hit_in   = 1'b0;
                  free_in  = 1'b0;
                  unl_in   = '0;
               end else begin
                  if (req_data.action == lspt_pkg::ACT_ADVANCE) begin
                     frame_in = frame_ff + 32'd1;
                  end
                  rsp_in            = '0;
                  rsp_in.live_count = 7'(count_ff);
                  strobe_in         = 1'b1;
               end
            end
         end
         lspt_pkg::ST_READ: begin
            state_in = lspt_pkg::ST_CMP;
         end
         lspt_pkg::ST_CMP: begin
            if (act_ff == lspt_pkg::ACT_SWEEP) begin
               if (active_ff[idx_ff] && cmp.far) begin
                  active_in[idx_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  unl_in = unl_ff + CNT_W'(1);
               end
            end else begin
               if (active_ff[idx_ff] && cmp.key_eq && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
               end
               if (!active_ff[idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = idx_ff;
               end
               if ((idx_ff == '0) || cmp.stamp_lt) begin
                  old_idx_in   = idx_ff;
                  old_stamp_in = rd_stamp;
                  old_key_in   = rd_key;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = lspt_pkg::ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = lspt_pkg::ST_READ;
            end
         end
         lspt_pkg::ST_FINISH: begin
            rsp_in    = '0;
            strobe_in = 1'b1;
            state_in  = lspt_pkg::ST_IDLE;
            if (act_ff == lspt_pkg::ACT_SWEEP) begin
               rsp_in.unloaded_count = 7'(unl_ff);
            end else if (hit_ff) begin
               rsp_in.found       = 1'b1;
               rsp_in.slot_index  = 6'(hit_idx_ff);
               rsp_in.dirty_state = dirty_ff[hit_idx_ff];
               if (act_ff == lspt_pkg::ACT_LOOKUP) begin
                  wr_en = 1'b1;
               end else if (act_ff == lspt_pkg::ACT_MARK) begin
                  dirty_in[hit_idx_ff] = 1'b1;
                  rsp_in.dirty_state   = 1'b1;
               end
            end else if (act_ff == lspt_pkg::ACT_LOOKUP) begin
               wr_en                  = 1'b1;
               wr_addr                = sel_idx;
               active_in[sel_idx]     = 1'b1;
               dirty_in[sel_idx]      = 1'b1;
               rsp_in.allocated_new   = 1'b1;
               rsp_in.slot_index      = 6'(sel_idx);
               rsp_in.dirty_state     = 1'b1;
               if (free_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  rsp_in.evicted     = 1'b1;
                  rsp_in.evicted_key = old_key_ff;
               end
            end
            rsp_in.live_count = 7'(count_in);
         end
         default: begin
            state_in = lspt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lspt_pkg::ST_IDLE;
         active_ff <= '0;
         dirty_ff  <= '0;
         count_ff  <= '0;
         frame_ff  <= '0;
         dist_ff   <= lspt_pkg::UNLOAD_DIST_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         dirty_ff  <= dirty_in;
         count_ff  <= count_in;
         frame_ff  <= frame_in;
         dist_ff   <= dist_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
      old_key_ff   <= old_key_in;
      unl_ff       <= unl_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: sv/lspt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lspt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire lspt_pkg::req_type req_data,
   input wire logic              rsp_strobe,
   input wire lspt_pkg::rsp_type rsp_data
);

   `LSPT_ASSERT(a_sweep_busy, clock, reset, (start && !busy && req_data.action == lspt_pkg::ACT_SWEEP) |=> busy)
   `LSPT_ASSERT(a_strobe_cause, clock, reset, rsp_strobe |-> ($past(start && !busy) || $past(busy)))
   `LSPT_ASSERT_IMP(a_evict_alloc, clock, reset, rsp_strobe && rsp_data.evicted, rsp_data.allocated_new && !rsp_data.found)
   `LSPT_ASSERT_IMP(a_noalloc_clean, clock, reset, rsp_strobe && !rsp_data.allocated_new, !rsp_data.evicted && rsp_data.evicted_key == 32'sd0)

endmodule

bind lru_slot_pool_table_unit lspt_checker u_lspt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

FILE: bench/tb_lru_slot_pool_table_unit.sv
`timescale 1ns / 1ps

module tb_lru_slot_pool_table_unit;

   localparam int POOL_SLOTS = 64;
   localparam int SCAN_CYCLES = 2 * POOL_SLOTS + 2;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 165;
   localparam int PHASES = 6;
   localparam logic [2:0] DIST_ADDR = 3'(4 * lspt_pkg::CSR_UNLOAD_DIST);
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef struct {
      lspt_pkg::req_type item;
      bit                known;
      lspt_pkg::rsp_type want;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   lspt_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   lspt_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   logic               pool_active [POOL_SLOTS];
   logic signed [31:0] pool_key [POOL_SLOTS];
   logic [31:0]        pool_stamp [POOL_SLOTS];
   logic               pool_dirty [POOL_SLOTS];
   logic [31:0]        frame_now;
   int                 live_slots;
   logic [15:0]        sweep_reach;

   lspt_pkg::rsp_type pending_results [$];
   script_row_type    script_rows [$];
   int                fail_count = 0;
   int                stall_cycles = 0;

   lru_slot_pool_table_unit #(.SLOTS(POOL_SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic clear_pool();
      int i;
      for (i = 0; i < POOL_SLOTS; i++) begin
         pool_active[i] = 1'b0;
         pool_key[i] = '0;
         pool_stamp[i] = '0;
         pool_dirty[i] = 1'b0;
      end
      frame_now = '0;
      live_slots = 0;
      sweep_reach = lspt_pkg::UNLOAD_DIST_RESET;
   endtask

   task automatic predict_pool_step(input lspt_pkg::req_type item,
                                    output lspt_pkg::rsp_type res);
      int i;
      int hit;
      int pick;
      logic [31:0] oldest;
      longint gap;
      res = '0;
      hit = -1;
      pick = -1;
      case (item.action)
         lspt_pkg::ACT_LOOKUP, lspt_pkg::ACT_FIND, lspt_pkg::ACT_MARK: begin
            for (i = 0; i < POOL_SLOTS; i++)
               if (hit < 0 && pool_active[i] && pool_key[i] == item.key)
                  hit = i;
            if (hit >= 0) begin
               res.found = 1'b1;
               res.slot_index = 6'(hit);
               if (item.action == lspt_pkg::ACT_LOOKUP)
                  pool_stamp[hit] = frame_now;
               else if (item.action == lspt_pkg::ACT_MARK)
                  pool_dirty[hit] = 1'b1;
               res.dirty_state = pool_dirty[hit];
            end else if (item.action == lspt_pkg::ACT_LOOKUP) begin
               for (i = 0; i < POOL_SLOTS; i++)
                  if (pick < 0 && !pool_active[i])
                     pick = i;
               if (pick >= 0) begin
                  live_slots++;
               end else begin
                  pick = 0;
                  oldest = pool_stamp[0];
                  for (i = 1; i < POOL_SLOTS; i++)
                     if (pool_stamp[i] < oldest) begin
                        oldest = pool_stamp[i];
                        pick = i;
                     end
                  res.evicted = 1'b1;
                  res.evicted_key = pool_key[pick];
               end
               pool_active[pick] = 1'b1;
               pool_key[pick] = item.key;
               pool_stamp[pick] = frame_now;
               pool_dirty[pick] = 1'b1;
               res.allocated_new = 1'b1;
               res.slot_index = 6'(pick);
               res.dirty_state = 1'b1;
            end
         end
         lspt_pkg::ACT_ADVANCE: frame_now = frame_now + 32'd1;
         lspt_pkg::ACT_SWEEP: begin
            for (i = 0; i < POOL_SLOTS; i++) begin
               if (pool_active[i]) begin
                  gap = longint'($signed(pool_key[i])) - longint'($signed(item.key));
                  if (gap < 0)
                     gap = -gap;
                  if (gap > longint'(sweep_reach)) begin
                     pool_active[i] = 1'b0;
                     if (live_slots > 0)
                        live_slots--;
                     res.unloaded_count = res.unloaded_count + 7'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      res.live_count = 7'(live_slots);
   endtask

   function automatic lspt_pkg::rsp_type slot_outcome(bit hit, int idx, bit alloc,
                                                      bit dirty, int live, int unloaded);
      lspt_pkg::rsp_type res;
      res = '0;
      res.found = hit;
      res.slot_index = 6'(idx);
      res.allocated_new = alloc;
      res.dirty_state = dirty;
      res.live_count = 7'(live);
      res.unloaded_count = 7'(unloaded);
      return res;
   endfunction

   task automatic add_row(input logic [2:0] act, input logic [31:0] key, input bit known,
                          input lspt_pkg::rsp_type want);
      script_row_type row;
      row.item.action = act;
      row.item.key = key;
      row.known = known;
      row.want = want;
      script_rows.push_back(row);
   endtask

   function automatic lspt_pkg::req_type pool_item(logic [31:0] base, int spread);
      lspt_pkg::req_type item;
      int roll;
      roll = $urandom_range(0, 99);
      item.key = base + 32'($urandom_range(0, spread - 1));
      if (roll < 50)
         item.action = lspt_pkg::ACT_LOOKUP;
      else if (roll < 63)
         item.action = lspt_pkg::ACT_FIND;
      else if (roll < 75)
         item.action = lspt_pkg::ACT_MARK;
      else if (roll < 86)
         item.action = lspt_pkg::ACT_ADVANCE;
      else if (roll < 90)
         item.action = lspt_pkg::ACT_SWEEP;
      else if (roll < 93)
         item.action = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
      else begin
         item.action = 3'($urandom_range(0, 7));
         item.key = $urandom;
      end
      return item;
   endfunction

   task automatic issue_item(input lspt_pkg::req_type item, input bit known,
                             input lspt_pkg::rsp_type typed);
      lspt_pkg::rsp_type want;
      req_data <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predict_pool_step(item, want);
      pending_results.push_back(known ? typed : want);
   endtask

   task automatic pace_sender(input bit closing);
      int kind;
      kind = $urandom_range(0, 9);
      if (closing || kind != 1)
         start <= 1'b0;
      if (kind == 0) begin
         while (pending_results.size() != 0)
            @(posedge clock);
      end else if (kind != 1 && !closing) begin
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic write_unload_distance(input logic [15:0] reach);
      while (pending_results.size() != 0 || busy)
         @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= DIST_ADDR;
      pwdata <= {16'd0, reach};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sweep_reach = reach;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      lspt_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing pending");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("found", want.found, rsp_data.found);
            compare_field("slot_index", want.slot_index, rsp_data.slot_index);
            compare_field("allocated_new", want.allocated_new, rsp_data.allocated_new);
            compare_field("evicted", want.evicted, rsp_data.evicted);
            compare_field("evicted_key", want.evicted_key, rsp_data.evicted_key);
            compare_field("dirty_state", want.dirty_state, rsp_data.dirty_state);
            compare_field("live_count", want.live_count, rsp_data.live_count);
            compare_field("unloaded_count", want.unloaded_count, rsp_data.unloaded_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("lru_slot_pool_table_unit test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [15:0] phase_dist [PHASES];
      logic [31:0] phase_base [PHASES];
      int phase;
      int sent;
      int burst;
      int b;
      int r;

      clear_pool();
      phase_dist[0] = 16'd0;
      phase_dist[1] = 16'hFFFF;
      phase_dist[2] = 16'($urandom);
      phase_dist[3] = 16'd2;
      phase_dist[4] = 16'd40;
      phase_dist[5] = 16'($urandom_range(0, 100));
      phase_base[0] = 32'h7FFF_FFD0;
      phase_base[1] = 32'h8000_0000;
      phase_base[2] = $urandom;
      phase_base[3] = 32'hFFFF_FFE0;
      phase_base[4] = $urandom;
      phase_base[5] = 32'h0000_0000;

      add_row(lspt_pkg::ACT_FIND, 32'h0000_0000, 1'b1, slot_outcome(0, 0, 0, 0, 0, 0));
      add_row(lspt_pkg::ACT_MARK, 32'h0000_0000, 1'b1, slot_outcome(0, 0, 0, 0, 0, 0));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h8000_0000, 1'b1, slot_outcome(0, 0, 1, 1, 1, 0));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 1'b1, slot_outcome(0, 1, 1, 1, 2, 0));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 1'b1, slot_outcome(1, 1, 0, 1, 2, 0));
      add_row(lspt_pkg::ACT_FIND, 32'h8000_0000, 1'b1, slot_outcome(1, 0, 0, 1, 2, 0));
      add_row(ACT_SPARE_5, 32'hFFFF_FFFF, 1'b1, slot_outcome(0, 0, 0, 0, 2, 0));
      add_row(ACT_SPARE_6, 32'hFFFF_FFFF, 1'b1, slot_outcome(0, 0, 0, 0, 2, 0));
      add_row(ACT_SPARE_7, 32'hFFFF_FFFF, 1'b1, slot_outcome(0, 0, 0, 0, 2, 0));
      add_row(lspt_pkg::ACT_ADVANCE, 32'h0000_0000, 1'b1, slot_outcome(0, 0, 0, 0, 2, 0));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h0000_0000, 1'b1, slot_outcome(0, 2, 1, 1, 3, 0));
      add_row(lspt_pkg::ACT_SWEEP, 32'h0000_0000, 1'b1, slot_outcome(0, 0, 0, 0, 1, 2));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h0000_0005, 1'b1, slot_outcome(0, 0, 1, 1, 2, 0));
      add_row(lspt_pkg::ACT_SWEEP, 32'h8000_0000, 1'b1, slot_outcome(0, 0, 0, 0, 0, 2));
      add_row(lspt_pkg::ACT_LOOKUP, 32'h0000_0008, 1'b0, '0);
      add_row(lspt_pkg::ACT_LOOKUP, 32'hFFFF_FFF8, 1'b0, '0);
      add_row(lspt_pkg::ACT_SWEEP, 32'h0000_0000, 1'b0, '0);
      add_row(lspt_pkg::ACT_FIND, 32'h0000_0008, 1'b0, '0);
      add_row(lspt_pkg::ACT_MARK, 32'hFFFF_FFF8, 1'b0, '0);
      add_row(lspt_pkg::ACT_MARK, 32'h0000_0063, 1'b0, '0);
      add_row(lspt_pkg::ACT_ADVANCE, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(lspt_pkg::ACT_LOOKUP, 32'h0000_0008, 1'b0, '0);
      add_row(lspt_pkg::ACT_SWEEP, 32'h0000_0009, 1'b0, '0);
      add_row(lspt_pkg::ACT_FIND, 32'hFFFF_FFF8, 1'b0, '0);
      add_row(lspt_pkg::ACT_LOOKUP, 32'h8000_0000, 1'b0, '0);
      add_row(lspt_pkg::ACT_SWEEP, 32'h7FFF_FFFF, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < script_rows.size(); r++) begin
         issue_item(script_rows[r].item, script_rows[r].known, script_rows[r].want);
         pace_sender(r == script_rows.size() - 1);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         write_unload_distance(phase_dist[phase]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
               burst = $urandom_range(20, 40);
            for (b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
               issue_item(pool_item(phase_base[phase], 72 + 6 * phase), 1'b0, '0);
               sent++;
            end
            pace_sender(sent >= PHASE_ITEMS);
         end
      end

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SCAN_CYCLES + 10) @(posedge clock);
      if (fail_count == 0)
         $display("lru_slot_pool_table_unit test passed");
      else
         $display("lru_slot_pool_table_unit test failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/lspt_pkg.sv
sv/lspt_slot_mem.sv
sv/lspt_cmp_unit.sv
sv/lru_slot_pool_table_unit.sv
sv/lspt_checker.sv
bench/tb_lru_slot_pool_table_unit.sv
